/* src/aes_pkg.sv */
// AES-128 package: S-box tables, GF(2^8) helpers and controller/datapath types.
// No dependencies.
`default_nettype none
package aes_pkg;

   localparam int unsigned NumRounds = 10;
   localparam int unsigned KeyWords  = 44;

   typedef logic [7:0]   byte_type;
   typedef logic [31:0]  word_type;
   typedef logic [127:0] block_type;
   typedef logic [3:0]   round_type;

   localparam logic [0:0] CsrKeyHigh = 1'b0;
   localparam logic [0:0] CsrKeyLow  = 1'b1;
   localparam logic CmdEncrypt = 1'b0;
   localparam logic CmdDecrypt = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic      load;      // take block and do initial key add
      logic      round;     // run one cipher round
      logic      last;      // final round (no mix)
      logic      decrypt;
      round_type rnum;      // round key index for this step
      logic      ks_start;  // start key expansion
      logic      ks_step;   // compute next round key
   } ctrl_type;

   localparam logic [7:0] Sbox [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] InvSbox [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic byte_type xtime(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // forward column mix
   function automatic word_type mix_col(input word_type w);
      byte_type a0, a1, a2, a3;
      a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
      return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
              a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
              a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
              xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

   // inverse mix = forward mix after a pre-multiply by {04,00,05,00}
   function automatic word_type inv_mix_col(input word_type w);
      byte_type a0, a1, a2, a3, u, v;
      a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
   endfunction

   function automatic word_type sub_word(input word_type w);
      return {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
   endfunction

endpackage
`default_nettype wire

/* src/aes_ctrl.sv */
// AES controller: sequences key expansion and cipher rounds.
// Depends on aes_pkg.
`default_nettype none
module aes_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              cmd,
   input  wire logic              key_write,
   output logic                   busy,
   output logic                   done,
   output aes_pkg::ctrl_type      ctrl
);
   import aes_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_KEY    = 3'b010,
      ST_CIPHER = 3'b100
   } state_type;

   state_type state_ff, state_in;
   round_type cnt_ff, cnt_in;
   logic      dec_ff, dec_in;
   logic      done_ff, done_in;

   assign busy = (state_ff != ST_IDLE);
   assign done = done_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dec_in   = dec_ff;
      done_in  = 1'b0;
      ctrl     = '0;
      ctrl.decrypt = dec_ff;
      case (state_ff)
         ST_IDLE: begin
            if (key_write) begin
               ctrl.ks_start = 1'b1;
               cnt_in   = 4'd1;
               state_in = ST_KEY;
            end else if (start) begin
               ctrl.load    = 1'b1;
               ctrl.decrypt = cmd;
               ctrl.rnum    = (cmd == CmdDecrypt) ? round_type'(NumRounds) : 4'd0;
               dec_in   = cmd;
               cnt_in   = 4'd1;
               state_in = ST_CIPHER;
            end
         end
         ST_KEY: begin
            ctrl.ks_step = 1'b1;
            ctrl.rnum    = cnt_ff;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == round_type'(NumRounds)) state_in = ST_IDLE;
         end
         ST_CIPHER: begin
            ctrl.round = 1'b1;
            ctrl.last  = (cnt_ff == round_type'(NumRounds));
            ctrl.rnum  = dec_ff ? round_type'(NumRounds) - cnt_ff : cnt_ff;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == round_type'(NumRounds)) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         dec_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         dec_ff   <= dec_in;
         done_ff  <= done_in;
      end
   end
endmodule
`default_nettype wire

/* src/aes_datapath.sv */
// AES datapath: key registers, round key memory, key expansion and round logic.
// Depends on aes_pkg.
`default_nettype none
module aes_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic                csr_sel,
   input  wire logic [63:0]         csr_data,
   input  wire aes_pkg::ctrl_type   ctrl,
   input  wire aes_pkg::block_type  blk_in,
   output aes_pkg::block_type       blk_out
);
   import aes_pkg::*;

   logic [63:0] key_hi_ff, key_lo_ff;
   block_type   rk_mem [NumRounds+1];   // one 128-bit row per round key
   block_type   prev_ff;                // last expanded round key
   byte_type    rcon_ff;
   block_type   state_ff;
   block_type   rk, sb, sr, mx, nxt, ks_next;
   word_type    t;

   // round keys are read at rnum; ks_step writes the same row, so use combinational
   // read only on the cipher side where no write happens (11 rows, small array)
   assign rk = rk_mem[ctrl.rnum];

   assign t = sub_word({prev_ff[23:0], prev_ff[31:24]}) ^ {rcon_ff, 24'h0};
   always_comb begin
      ks_next[127:96] = prev_ff[127:96] ^ t;
      ks_next[95:64]  = prev_ff[95:64]  ^ ks_next[127:96];
      ks_next[63:32]  = prev_ff[63:32]  ^ ks_next[95:64];
      ks_next[31:0]   = prev_ff[31:0]   ^ ks_next[63:32];
   end

   // byte i of the block is at bits 127-8i; column c holds bytes 4c..4c+3
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (ctrl.decrypt) begin
               sr[127-8*(((c+r)%4)*4+r) -: 8] = state_ff[127-8*(c*4+r) -: 8];
            end else begin
               sr[127-8*(c*4+r) -: 8] = state_ff[127-8*(((c+r)%4)*4+r) -: 8];
            end
         end
      end
      for (int i = 0; i < 16; i++) begin
         sb[127-8*i -: 8] = ctrl.decrypt ? InvSbox[sr[127-8*i -: 8]] : Sbox[sr[127-8*i -: 8]];
      end
      if (ctrl.decrypt) begin
         for (int c = 0; c < 4; c++) begin
            mx[127-32*c -: 32] = inv_mix_col(sb[127-32*c -: 32] ^ rk[127-32*c -: 32]);
         end
         nxt = ctrl.last ? (sb ^ rk) : mx;
      end else begin
         for (int c = 0; c < 4; c++) begin
            mx[127-32*c -: 32] = mix_col(sb[127-32*c -: 32]);
         end
         nxt = (ctrl.last ? sb : mx) ^ rk;
      end
   end

   assign blk_out = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (csr_we) begin
         if (csr_sel == CsrKeyHigh) key_hi_ff <= csr_data;
         else key_lo_ff <= csr_data;
      end
      if (ctrl.ks_start) begin
         rk_mem[0] <= {key_hi_ff, key_lo_ff};
         prev_ff   <= {key_hi_ff, key_lo_ff};
         rcon_ff   <= 8'h01;
      end
      if (ctrl.ks_step) begin
         rk_mem[ctrl.rnum] <= ks_next;
         prev_ff <= ks_next;
         rcon_ff <= xtime(rcon_ff);
      end
      if (ctrl.load) state_ff <= blk_in ^ rk;
      else if (ctrl.round) state_ff <= nxt;
   end
endmodule
`default_nettype wire

/* src/aes128_block_cipher_core.sv */
// AES-128 core, top level: joins the controller and the datapath.
// Depends on aes_pkg, aes_ctrl, aes_datapath.
// A start transfer does the initial key add, then ten rounds follow, one per cycle;
// rsp_valid comes with the last round's result. A new start is not taken while busy.
// Key write: expansion stores the key as round key 0, then one round key per cycle, with busy high.
// Reset is synchronous, active high; key registers clear to zero, schedule undefined.
// rsp_valid is a one-cycle strobe; the receiver cannot stall it.
`default_nettype none
module aes128_block_cipher_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_command,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   output logic             rsp_valid,
   output logic [63:0]      rsp_result_high,
   output logic [63:0]      rsp_result_low,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import aes_pkg::*;

   ctrl_type  ctrl;
   block_type blk_out;
   logic      ctrl_busy;
   logic      csr_xfer;
   logic      ks_go_ff;

   // a key register transfer latches the value and kicks off expansion;
   // the write wins over a same-cycle start, which is not taken
   assign csr_ready = ~ctrl_busy & ~ks_go_ff;
   assign csr_xfer  = csr_valid & csr_ready;
   assign busy      = ctrl_busy | ks_go_ff | csr_valid;

   // the datapath reads the key registers in the cycle after the transfer,
   // so expansion starts from the updated key
   always_ff @(posedge clock) begin
      if (reset) ks_go_ff <= 1'b0;
      else ks_go_ff <= csr_xfer;
   end

   aes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start & ~csr_valid),
      .cmd       (req_command),
      .key_write (ks_go_ff),
      .busy      (ctrl_busy),
      .done      (rsp_valid),
      .ctrl      (ctrl)
   );

   aes_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_xfer),
      .csr_sel  (csr_index),
      .csr_data (csr_data),
      .ctrl     (ctrl),
      .blk_in   ({req_block_high, req_block_low}),
      .blk_out  (blk_out)
   );

   assign rsp_result_high = blk_out[127:64];
   assign rsp_result_low  = blk_out[63:0];
endmodule
`default_nettype wire
